// ----- src/assert_macros.svh -----
// Assertion helpers shared by the timer table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mss_pkg.sv -----
package mss_pkg;

  localparam int SLOTS       = 16;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ALLOC_W     = $clog2(2 * SLOTS + 1);
  localparam int ELAPSED_MAX = 65535;

  typedef enum logic [2:0] {
    OP_ARM_P   = 3'd0,
    OP_ARM_O   = 3'd1,
    OP_CLEAR_P = 3'd2,
    OP_CLEAR_O = 3'd3,
    OP_TICK    = 3'd4,
    OP_PROCESS = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    K_ACCEPT = 3'd0,
    K_REFUSE = 3'd1,
    K_DONE   = 3'd2,
    K_PFIRE  = 3'd3,
    K_OFIRE  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_ACTIVE  = 2'd1,
    ST_PENDING = 2'd2
  } slot_st_e;

  typedef enum logic [2:0] {
    TB_NONE,
    TB_ARM,
    TB_FREE,
    TB_MARK,
    TB_EL
  } tbl_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CLEAR,
    S_WALK,
    S_DONE
  } state_e;

  typedef struct packed {
    tbl_op_e     op;
    logic [15:0] el;
    logic [15:0] len;
    logic [7:0]  hd;
  } tbl_req_t;

  typedef struct packed {
    slot_st_e    status;
    logic [15:0] el;
    logic [15:0] len;
    logic [7:0]  hd;
  } tbl_rsp_t;

  typedef struct packed {
    logic [15:0] el;
    logic [15:0] len;
    logic [15:0] add;
  } alu_req_t;

  typedef struct packed {
    logic        fire;
    logic [15:0] next_el;
  } alu_rsp_t;

  function automatic logic [3:0] to_slot_field(logic [IDX_W-1:0] i);
    logic [31:0] w;
    w = 32'(i);
    return w[3:0];
  endfunction

  function automatic logic [5:0] to_live_field(logic [ALLOC_W-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[5:0];
  endfunction

endpackage

// ----- src/mss_table.sv -----
module mss_table (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [mss_pkg::IDX_W-1:0] idx_i,
  input  mss_pkg::tbl_req_t        req_i,
  output mss_pkg::tbl_rsp_t        rsp_o
);
  import mss_pkg::*;

  slot_st_e    status_q [SLOTS];
  logic [15:0] el_q     [SLOTS];
  logic [15:0] len_q    [SLOTS];
  logic [7:0]  hd_q     [SLOTS];

  // Status carries the slot's life cycle and is the only part that is reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        status_q[i] <= ST_FREE;
      end
    end else begin
      case (req_i.op)
        TB_ARM:  status_q[idx_i] <= ST_ACTIVE;
        TB_FREE: status_q[idx_i] <= ST_FREE;
        TB_MARK: status_q[idx_i] <= ST_PENDING;
        default: ;
      endcase
    end
  end

  // Data of a free slot is never looked at, so it is simply rewritten on arm.
  always_ff @(posedge clk_i) begin
    case (req_i.op)
      TB_ARM: begin
        el_q[idx_i]  <= '0;
        len_q[idx_i] <= req_i.len;
        hd_q[idx_i]  <= req_i.hd;
      end
      TB_EL:   el_q[idx_i] <= req_i.el;
      default: ;
    endcase
  end

  assign rsp_o.status = status_q[idx_i];
  assign rsp_o.el     = el_q[idx_i];
  assign rsp_o.len    = len_q[idx_i];
  assign rsp_o.hd     = hd_q[idx_i];

endmodule

// ----- src/mss_alu.sv -----
module mss_alu (
  input  mss_pkg::alu_req_t req_i,
  output mss_pkg::alu_rsp_t rsp_o
);
  import mss_pkg::*;

  logic [16:0] sum;
  logic [16:0] rem;

  assign sum = {1'b0, req_i.el} + {1'b0, req_i.add};
  assign rem = sum - {1'b0, req_i.len};

  assign rsp_o.fire    = (sum >= {1'b0, req_i.len});
  assign rsp_o.next_el = rsp_o.fire ? rem[15:0] : sum[15:0];

endmodule

// ----- src/mss_ctrl.sv -----
module mss_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                op_i,
  input  logic [15:0]               period_ticks_i,
  input  logic [7:0]                handler_tag_i,
  input  logic [7:0]                slot_id_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                kind_o,
  output logic [3:0]                slot_index_o,
  output logic [7:0]                fired_tag_o,
  output logic [5:0]                live_count_o,
  output logic                      last_o,
  output logic [mss_pkg::IDX_W-1:0] tbl_idx_o,
  output mss_pkg::tbl_req_t         p_req_o,
  output mss_pkg::tbl_req_t         o_req_o,
  input  mss_pkg::tbl_rsp_t         p_rsp_i,
  input  mss_pkg::tbl_rsp_t         o_rsp_i,
  output mss_pkg::alu_req_t         alu_req_o,
  input  mss_pkg::alu_rsp_t         alu_rsp_i
);
  import mss_pkg::*;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   idx_q;
  logic               sel_q;
  logic [15:0]        period_q;
  logic [7:0]         tag_q;
  logic [7:0]         id_q;
  kind_e              kind_q;
  logic [15:0]        add_q;
  logic [31:0]        tick_q;
  logic [31:0]        lastp_q;
  logic [ALLOC_W-1:0] alloc_q;

  logic               out_valid_q;
  logic [2:0]         kind_out_q;
  logic [3:0]         slot_out_q;
  logic [7:0]         tag_out_q;
  logic [5:0]         live_out_q;
  logic               last_out_q;

  logic               accept;
  logic               can_emit;
  logic               idx_last;
  logic [31:0]        delta;
  logic [15:0]        add_sat;
  logic               arm_bad;
  op_e                op_in;

  tbl_rsp_t           cur;
  tbl_req_t           cur_req;
  logic               adv;
  logic               arm_done;
  logic               alloc_inc;
  logic               alloc_dec;
  logic               emit;
  kind_e              emit_kind;
  logic [3:0]         emit_slot;
  logic [7:0]         emit_tag;
  logic [5:0]         emit_live;
  logic               emit_last;

  assign op_in      = op_e'(op_i);
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign can_emit   = !out_valid_q || !out_stall_i;
  assign idx_last   = (idx_q == IDX_W'(SLOTS - 1));
  assign delta      = tick_q - lastp_q;
  assign add_sat    = (delta > 32'(ELAPSED_MAX)) ? 16'(ELAPSED_MAX) : delta[15:0];
  assign arm_bad    = (period_ticks_i == 16'd0) || (handler_tag_i == 8'd0);

  assign cur       = sel_q ? o_rsp_i : p_rsp_i;
  assign tbl_idx_o = (state_q == S_CLEAR) ? id_q[IDX_W-1:0] : idx_q;

  assign alu_req_o.el  = cur.el;
  assign alu_req_o.len = cur.len;
  assign alu_req_o.add = add_q;

  always_comb begin
    p_req_o = cur_req;
    o_req_o = cur_req;
    if (sel_q) begin
      p_req_o.op = TB_NONE;
    end else begin
      o_req_o.op = TB_NONE;
    end
  end

  // Output logic: one slot of the selected table is examined per cycle while the output is not stalled.
  always_comb begin
    cur_req     = '{op: TB_NONE, el: alu_rsp_i.next_el, len: period_q, hd: tag_q};
    adv         = 1'b0;
    arm_done    = 1'b0;
    alloc_inc   = 1'b0;
    alloc_dec   = 1'b0;
    emit        = 1'b0;
    emit_kind   = K_DONE;
    emit_slot   = '0;
    emit_tag    = '0;
    emit_live   = to_live_field(alloc_q);
    emit_last   = 1'b1;
    unique case (state_q)
      S_IDLE: ;
      S_SCAN: begin
        if (cur.status == ST_FREE) begin
          if (can_emit) begin
            cur_req.op = TB_ARM;
            alloc_inc  = 1'b1;
            arm_done   = 1'b1;
            emit       = 1'b1;
            emit_kind  = K_ACCEPT;
            emit_slot  = to_slot_field(idx_q);
            emit_live  = to_live_field(ALLOC_W'(alloc_q + 1'b1));
          end
        end else begin
          adv = 1'b1;
        end
      end
      S_CLEAR: begin
        if ((32'(id_q) < SLOTS) && (cur.status == ST_ACTIVE)) begin
          cur_req.op = TB_MARK;
        end
      end
      S_WALK: begin
        case (cur.status)
          ST_PENDING: begin
            cur_req.op = TB_FREE;
            alloc_dec  = 1'b1;
            adv        = 1'b1;
          end
          ST_ACTIVE: begin
            if (!alu_rsp_i.fire) begin
              cur_req.op = TB_EL;
              adv        = 1'b1;
            end else if (can_emit) begin
              adv       = 1'b1;
              emit      = 1'b1;
              emit_slot = to_slot_field(idx_q);
              emit_tag  = cur.hd;
              emit_last = 1'b0;
              if (sel_q) begin
                cur_req.op = TB_FREE;
                alloc_dec  = 1'b1;
                emit_kind  = K_OFIRE;
                emit_live  = to_live_field(ALLOC_W'(alloc_q - 1'b1));
              end else begin
                cur_req.op = TB_EL;
                emit_kind  = K_PFIRE;
              end
            end
          end
          default: adv = 1'b1;
        endcase
      end
      S_DONE: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_kind = kind_q;
        end
      end
      default: ;
    endcase
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_in)
            OP_ARM_P, OP_ARM_O:     state_d = arm_bad ? S_DONE : S_SCAN;
            OP_CLEAR_P, OP_CLEAR_O: state_d = S_CLEAR;
            OP_PROCESS:             state_d = (delta == 32'd0) ? S_DONE : S_WALK;
            default:                state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (arm_done) begin
          state_d = S_IDLE;
        end else if (adv && idx_last) begin
          state_d = S_DONE;
        end
      end
      S_CLEAR: state_d = S_DONE;
      S_WALK: begin
        if (adv && idx_last && sel_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (can_emit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      sel_q       <= 1'b0;
      kind_q      <= K_DONE;
      tick_q      <= '0;
      lastp_q     <= '0;
      alloc_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      alloc_q <= alloc_q + ALLOC_W'(alloc_inc) - ALLOC_W'(alloc_dec);
      if (accept) begin
        idx_q  <= '0;
        sel_q  <= (op_in == OP_ARM_O) || (op_in == OP_CLEAR_O);
        kind_q <= ((op_in == OP_ARM_P) || (op_in == OP_ARM_O)) && arm_bad ? K_REFUSE : K_DONE;
        if (op_in == OP_TICK) begin
          tick_q <= tick_q + 32'd1;
        end
        if (op_in == OP_PROCESS) begin
          lastp_q <= tick_q;
        end
      end else if (adv) begin
        idx_q <= idx_last ? '0 : idx_q + 1'b1;
        if (idx_last && (state_q == S_WALK)) begin
          sel_q <= 1'b1;
        end
        if (idx_last && (state_q == S_SCAN)) begin
          kind_q <= K_REFUSE;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      period_q <= period_ticks_i;
      tag_q    <= handler_tag_i;
      id_q     <= slot_id_i;
      add_q    <= add_sat;
    end
    if (emit) begin
      kind_out_q <= emit_kind;
      slot_out_q <= emit_slot;
      tag_out_q  <= emit_tag;
      live_out_q <= emit_live;
      last_out_q <= emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_out_q;
  assign slot_index_o = slot_out_q;
  assign fired_tag_o  = tag_out_q;
  assign live_count_o = live_out_q;
  assign last_o       = last_out_q;

endmodule

// ----- src/multi_slot_software_timer.sv -----
// A process request after new ticks walks both slot tables through the shared add/compare
// unit, one slot per cycle while the output is not stalled.
// Throughput: one request at a time; the next is taken once the final result is registered.
// Reset (rst_ni low, asynchronous) frees every slot and clears all counters at once.
`include "assert_macros.svh"

module multi_slot_software_timer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [15:0] period_ticks_i,
  input  logic [7:0]  handler_tag_i,
  input  logic [7:0]  slot_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [3:0]  slot_index_o,
  output logic [7:0]  fired_tag_o,
  output logic [5:0]  live_count_o,
  output logic        last_o
);
  import mss_pkg::*;

  // Both tables share one slot index; only the selected table is written.
  logic [IDX_W-1:0] tbl_idx;
  tbl_req_t         p_req;
  tbl_req_t         o_req;
  tbl_rsp_t         p_rsp;
  tbl_rsp_t         o_rsp;
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;

  // The sequencer owns the request handshake, the tick counters, the
  // allocation count and the output register. A result waits in that
  // register while the sequencer carries on with the walk or the next request.
  mss_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .period_ticks_i (period_ticks_i),
    .handler_tag_i  (handler_tag_i),
    .slot_id_i      (slot_id_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .slot_index_o   (slot_index_o),
    .fired_tag_o    (fired_tag_o),
    .live_count_o   (live_count_o),
    .last_o         (last_o),
    .tbl_idx_o      (tbl_idx),
    .p_req_o        (p_req),
    .o_req_o        (o_req),
    .p_rsp_i        (p_rsp),
    .o_rsp_i        (o_rsp),
    .alu_req_o      (alu_req),
    .alu_rsp_i      (alu_rsp)
  );

  // Periodic slot table.
  mss_table u_ptbl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .idx_i  (tbl_idx),
    .req_i  (p_req),
    .rsp_o  (p_rsp)
  );

  // One-shot slot table.
  mss_table u_otbl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .idx_i  (tbl_idx),
    .req_i  (o_req),
    .rsp_o  (o_rsp)
  );

  // The single elapsed-time adder and period comparator used for each active
  // slot of a process walk.
  mss_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Every accepted request leaves the block busy in the following cycle.
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "request accepted but block not busy")

  // Only fire events are non-final results.
  `ASSERT_IMPLIES(a_nonlast_is_fire, clk_i, rst_ni, out_valid_o && !last_o, (kind_o == K_PFIRE) || (kind_o == K_OFIRE), "non-final result is not a fire event")

  // A fired slot always carries a handler tag, since zero tags are refused on arm.
  `ASSERT_IMPLIES(a_fire_has_tag, clk_i, rst_ni, out_valid_o && ((kind_o == K_PFIRE) || (kind_o == K_OFIRE)), fired_tag_o != 8'd0, "fire event without handler tag")

endmodule
